// ===== sv/double_ended_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_core_macros.svh
// Assertion macros for the deque core. Clock is clk, reset is rst.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the deque core and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int DATA_W           = 32;
  localparam int OCC_W            = 5;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    action_t                   action;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  popped;
    status_t                   status;
    logic        [OCC_W-1:0]   occupancy;
  } rsp_t;

  // memory port strobes from the controller
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== sv/dq_mem.sv =====
// ----------------------------------------------------------------------------
// dq_mem
// Word store of the deque: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_mem import dq_pkg::*; #(
  parameter int DEPTH = DEFAULT_CAPACITY,
  parameter int AW    = $clog2(DEFAULT_CAPACITY)
) (
  input  wire logic              clk,
  input  wire mem_ctl_t          ctl,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data registered on the strobe, held otherwise
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Front pointer and count of the deque; decodes each action into a memory
// access and the response status.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl import dq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int IDXW     = $clog2(DEFAULT_CAPACITY),
  parameter int CNTW     = $clog2(DEFAULT_CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire req_t              req,
  output mem_ctl_t               mem_ctl,
  output logic      [IDXW-1:0]   waddr,
  output logic      [DATA_W-1:0] wdata,
  output logic      [IDXW-1:0]   raddr,
  output status_t                status,
  output logic                   pop_ok,
  output logic      [CNTW-1:0]   held,
  output logic      [CNTW-1:0]   held_next
);

  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CAPACITY - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(CAPACITY);
  localparam logic [CNTW:0]   CAP_EXT  = (CNTW + 1)'(CAPACITY);

  logic [IDXW-1:0] front;
  logic [IDXW-1:0] front_next;
  logic [IDXW-1:0] prev_front;
  logic [IDXW-1:0] succ_front;
  logic [CNTW:0]   back_sum;
  logic [CNTW:0]   last_sum;
  logic [IDXW-1:0] back_slot;
  logic [IDXW-1:0] last_slot;
  logic            is_full;
  logic            is_empty;

  // neighbor slots of the front, wrapping at the capacity
  assign prev_front = (front == '0) ? LAST_IDX : front - 1'b1;
  assign succ_front = (front == LAST_IDX) ? '0 : front + 1'b1;

  // slot after the back word and slot of the back word; sums stay below 2x
  assign back_sum  = {{(CNTW + 1 - IDXW){1'b0}}, front} + {1'b0, held};
  assign last_sum  = back_sum - 1'b1;
  assign back_slot = (back_sum >= CAP_EXT) ? IDXW'(back_sum - CAP_EXT) : IDXW'(back_sum);
  assign last_slot = (last_sum >= CAP_EXT) ? IDXW'(last_sum - CAP_EXT) : IDXW'(last_sum);

  assign is_full  = (held == FULL_CNT);
  assign is_empty = (held == '0);

  // action decode
  always_comb begin
    status        = ST_OK;
    pop_ok        = 1'b0;
    front_next    = front;
    held_next     = held;
    waddr         = back_slot;
    raddr         = front;
    wdata         = req.value;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    case (req.action)
      ACT_PUSH_FRONT: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          front_next    = prev_front;
          waddr         = prev_front;
          held_next     = held + 1'b1;
          mem_ctl.wr_en = accept;
        end
      end
      ACT_PUSH_BACK: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          waddr         = back_slot;
          held_next     = held + 1'b1;
          mem_ctl.wr_en = accept;
        end
      end
      ACT_POP_FRONT: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          raddr         = front;
          front_next    = succ_front;
          held_next     = held - 1'b1;
          pop_ok        = 1'b1;
          mem_ctl.rd_en = accept;
        end
      end
      ACT_POP_BACK: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          raddr         = last_slot;
          held_next     = held - 1'b1;
          pop_ok        = 1'b1;
          mem_ctl.rd_en = accept;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // pointer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      held  <= '0;
    end else if (accept) begin
      front <= front_next;
      held  <= held_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
// Each request transaction carries one action (push front, push back, pop
// front, pop back) and gives exactly one response transaction with the
// popped word, a status (ok, full push refused, empty pop refused) and the
// word count after the action. A new request is taken every cycle while the
// response side keeps up; the response is registered, as is the store's read
// port. Pointer and count update at request time, so back-to-back actions
// never wait on each other. No clearing pass follows reset: entries are only
// read after being written.
`default_nettype none

module double_ended_queue_core import dq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

`include "double_ended_queue_core_macros.svh"

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);

  mem_ctl_t          mem_ctl;
  logic [IDXW-1:0]   waddr;
  logic [IDXW-1:0]   raddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;
  status_t           status;
  logic              pop_ok;
  logic [CNTW-1:0]   held;
  logic [CNTW-1:0]   held_next;
  logic              req_accept;

  status_t           status_q;
  logic              pop_q;
  logic [OCC_W-1:0]  occ_q;

  // response register frees the request side when empty or being drained
  assign req_ready  = !rsp_valid || rsp_ready;
  assign req_accept = req_valid && req_ready;

  dq_ctrl #(
    .CAPACITY (CAPACITY),
    .IDXW     (IDXW),
    .CNTW     (CNTW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (req_accept),
    .req       (req),
    .mem_ctl   (mem_ctl),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .status    (status),
    .pop_ok    (pop_ok),
    .held      (held),
    .held_next (held_next)
  );

  dq_mem #(
    .DEPTH (CAPACITY),
    .AW    (IDXW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // response metadata; popped word comes from the store's read register
  always_ff @(posedge clk) begin
    if (req_accept) begin
      status_q <= status;
      pop_q    <= pop_ok;
      occ_q    <= OCC_W'(held_next);
    end
  end

  always_comb begin
    rsp.popped    = pop_q ? rdata : '0;
    rsp.status    = status_q;
    rsp.occupancy = occ_q;
  end

  // checks
  `DQ_ASSERT_NOW(a_held_bound, 1'b1, held <= CNTW'(CAPACITY), "count above capacity")
  `DQ_ASSERT_NOW(a_mem_excl, 1'b1, !(mem_ctl.wr_en && mem_ctl.rd_en), "read and write together")
  `DQ_ASSERT_NEXT(a_rsp_follows, req_accept, rsp_valid, "no response after request")
  `DQ_ASSERT_NOW(a_refused_zero, rsp_valid && rsp.status != ST_OK, rsp.popped == '0, "refused action popped data")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the double-ended queue core.
// ----------------------------------------------------------------------------
// A driver sends request transactions from a queue of pending actions in
// bursts with random gaps. A monitor keeps its own deque, predicts the
// response for every accepted request, and checks each accepted response
// field by field against the oldest prediction. The response side stalls
// on a pattern of its own. Stimulus opens with a directed run over empty
// pops, full pushes, extreme words and front index wrap. Random segments
// follow that lean toward filling, draining or mixing the queue, so it
// hits full and empty often.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import dq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = DEFAULT_CAPACITY;
  localparam int RANDOM_N   = 1525;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    req_t r;
    bit   drain_first;  // hold this one back until every response is in
  } pending_t;

  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_t;
  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_LONG} rx_mode_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_ready = 1'b0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;

  double_ended_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  pending_t pending_req_q[$];
  rsp_t     expected_rsp_q[$];
  int       outstanding = 0;
  int       errors      = 0;

  // deque shadow state
  logic signed [DATA_W-1:0] deque_mem [DEPTH];
  int                       deque_front;
  int                       deque_count;

  // Apply one action to the shadow deque and return the response it gives.
  function automatic rsp_t step_deque(req_t r);
    rsp_t res;
    res.popped    = '0;
    res.status    = ST_OK;
    case (r.action)
      ACT_PUSH_FRONT: begin
        if (deque_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          deque_front = (deque_front + DEPTH - 1) % DEPTH;
          deque_mem[deque_front] = r.value;
          deque_count++;
        end
      end
      ACT_PUSH_BACK: begin
        if (deque_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          deque_mem[(deque_front + deque_count) % DEPTH] = r.value;
          deque_count++;
        end
      end
      ACT_POP_FRONT: begin
        if (deque_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = deque_mem[deque_front];
          deque_front = (deque_front + 1) % DEPTH;
          deque_count--;
        end
      end
      default: begin
        if (deque_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = deque_mem[(deque_front + deque_count - 1) % DEPTH];
          deque_count--;
        end
      end
    endcase
    res.occupancy = deque_count[OCC_W-1:0];
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(action_t a, logic [DATA_W-1:0] v, bit drain);
    pending_t p;
    p.r.action    = a;
    p.r.value     = v;
    p.drain_first = drain;
    pending_req_q.push_back(p);
  endtask

  // Driver: bursts of transactions with random gaps
  pending_t next_item;
  bit       sent_now;
  int       burst_left;
  int       gap_left;

  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      sent_now = req_valid && req_ready;
      if (req_valid && !sent_now) begin
        // hold the current transaction
      end else if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_req_q.size() == 0 ||
                   (pending_req_q[0].drain_first && (sent_now || outstanding != 0))) begin
        req_valid <= 1'b0;
      end else begin
        next_item = pending_req_q.pop_front();
        req       <= next_item.r;
        req_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Response side stall pattern
  rx_mode_t rx_mode;
  int       rx_mode_left;
  int       rx_stall_left;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready     <= 1'b0;
      rx_mode       <= RX_ALWAYS;
      rx_mode_left  <= 0;
      rx_stall_left <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 2));
        rx_mode_left <= $urandom_range(32, 256);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: rsp_ready <= 1'b1;
        RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
        default: begin
          if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            rsp_ready     <= 1'b0;
          end else if ($urandom_range(0, 19) == 0) begin
            rx_stall_left <= $urandom_range(4, 24);
            rsp_ready     <= 1'b0;
          end else begin
            rsp_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Monitor: predict on each request, check each response
  rsp_t want;

  always @(posedge clk) begin
    if (rst) begin
      deque_front = 0;
      deque_count = 0;
      expected_rsp_q.delete();
      outstanding <= 0;
    end else begin
      if (req_valid && req_ready)
        expected_rsp_q.push_back(step_deque(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t unexpected response: expected none, actual popped %0d status %0d occ %0d",
                   $time, rsp.popped, rsp.status, rsp.occupancy);
          errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.popped !== want.popped) begin
            $display("%0t popped mismatch: expected %0d, actual %0d",
                     $time, want.popped, rsp.popped);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $time, want.status, rsp.status);
            errors++;
          end
          if (rsp.occupancy !== want.occupancy) begin
            $display("%0t occupancy mismatch: expected %0d, actual %0d",
                     $time, want.occupancy, rsp.occupancy);
            errors++;
          end
        end
      end
      outstanding <= expected_rsp_q.size();
    end
  end

  // Watchdog: cycles with no transaction on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  int   added;
  int   seg_len;
  seg_t seg;
  bit   want_push;

  initial begin
    // empty pops, then front push wraps the front index below zero
    add_item(ACT_POP_FRONT, pick_word(), 1'b0);
    add_item(ACT_POP_BACK, pick_word(), 1'b0);
    add_item(ACT_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
    add_item(ACT_POP_BACK, '0, 1'b0);
    add_item(ACT_PUSH_BACK, 32'h8000_0000, 1'b0);
    add_item(ACT_POP_FRONT, '1, 1'b0);
    // fill to capacity from both ends
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 6)
        0:       add_item(ACT_PUSH_FRONT, 32'h0000_0000, 1'b0);
        1:       add_item(ACT_PUSH_BACK, 32'hffff_ffff, 1'b0);
        2:       add_item(ACT_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
        3:       add_item(ACT_PUSH_BACK, 32'h8000_0000, 1'b0);
        4:       add_item(ACT_PUSH_FRONT, 32'h5555_5555, 1'b0);
        default: add_item(ACT_PUSH_BACK, 32'haaaa_aaaa, 1'b0);
      endcase
    end
    // full pushes at both ends, then a pop off the full queue
    add_item(ACT_PUSH_FRONT, pick_word(), 1'b0);
    add_item(ACT_PUSH_BACK, pick_word(), 1'b0);
    add_item(ACT_POP_FRONT, pick_word(), 1'b0);

    // random segments leaning toward fill, drain or mix
    added = 0;
    while (added < RANDOM_N) begin
      seg     = seg_t'($urandom_range(0, 2));
      seg_len = $urandom_range(8, 64);
      for (int k = 0; k < seg_len && added < RANDOM_N; k++) begin
        case (seg)
          SEG_FILL:  want_push = ($urandom_range(0, 99) < 85);
          SEG_DRAIN: want_push = ($urandom_range(0, 99) < 15);
          default:   want_push = 1'($urandom_range(0, 1));
        endcase
        if (want_push)
          add_item($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_word(),
                   (added == 0) || (k == 0 && $urandom_range(0, 7) == 0));
        else
          add_item($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, pick_word(),
                   (added == 0) || (k == 0 && $urandom_range(0, 7) == 0));
        added++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
      #1;
    end while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
    repeat (8) @(posedge clk);

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
